FILE: rtl/core/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

	// field widths
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	// width of the day count taken from the input port (16 here)
	localparam int ADD_WIDTH = 16;

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = {YEAR_W{1'b1}};

	// leap-cycle modulus and the shift of its largest multiple below 2^YEAR_W
	localparam int                 CYCLE_YEARS = 400;
	localparam logic [2:0]         RED_TOP     = 3'd5;
	localparam logic [8:0]         CYCLE_LAST  = 9'(CYCLE_YEARS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CLAMP,
		ST_WALK
	} gda_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       reduce;
		logic [2:0] red_shift;
		logic       clamp;
		logic       walk;
		logic       publish;
	} gda_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic finish;
	} gda_stat_t;

	// leap year from the year modulo 400
	function automatic logic is_leap(input logic [8:0] rem);
		logic hundred;
		hundred = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
		return (rem == 9'd0) || ((rem[1:0] == 2'b00) && !hundred);
	endfunction

	// length of month m (1..12)
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		if (m == MONTH_FEB) begin
			n = leap ? DAY_W'(29) : DAY_W'(28);
		end else if (m inside {MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11)}) begin
			n = DAY_W'(30);
		end else begin
			n = DAY_W'(31);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer for the date adder: load, year reduction, day clamp, month walk,
// and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl import gda_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire gda_stat_t stat,
	output gda_cmd_t       cmd
);

	gda_state_t state_q, state_d;
	logic [2:0] red_cnt_q;
	logic       out_valid_q;
	logic       out_free;
	logic       in_take;

	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (red_cnt_q == 3'd0) state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (stat.finish && out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd.load      = in_take;
		cmd.reduce    = (state_q == ST_REDUCE);
		cmd.red_shift = red_cnt_q;
		cmd.clamp     = (state_q == ST_CLAMP);
		cmd.walk      = (state_q == ST_WALK);
		cmd.publish   = (state_q == ST_WALK) && stat.finish && out_free;
	end

	assign out_valid = out_valid_q;

	// state, reduction count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_cnt_q   <= RED_TOP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				red_cnt_q <= RED_TOP;
			end else if (state_q == ST_REDUCE && red_cnt_q != 3'd0) begin
				red_cnt_q <= red_cnt_q - 3'd1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.publish && out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	a_load_starts_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_REDUCE) && (red_cnt_q == RED_TOP))
		else $error("accepted item did not start reduction");

	a_reduce_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REDUCE && red_cnt_q == 3'd0) |=> state_q == ST_CLAMP)
		else $error("reduction did not end in clamp");

	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published result not valid");

endmodule

`default_nettype wire

FILE: rtl/core/gda_dpath.sv
// ----------------------------------------------------------------------------
// gda_dpath
// Datapath of the date adder: working date, remaining count, year modulo
// 400, one month step per cycle, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gda_dpath import gda_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gda_cmd_t           cmd,
	output gda_stat_t               stat,
	input  wire logic [MONTH_W-1:0] start_month,
	input  wire logic [DAY_W-1:0]   start_day,
	input  wire logic [YEAR_W-1:0]  start_year,
	input  wire logic [15:0]        day_count,
	output logic [MONTH_W-1:0]      end_month,
	output logic [DAY_W-1:0]        end_day,
	output logic [YEAR_W-1:0]       end_year,
	output logic                    year_overflow
);

	logic [MONTH_W-1:0]   month_q;
	logic [DAY_W-1:0]     day_q;
	logic [YEAR_W-1:0]    year_q;
	logic [YEAR_W-1:0]    rem_q;
	logic [ADD_WIDTH-1:0] left_q;
	logic                 ovf_q;

	logic [DAY_W-1:0]     len;
	logic [DAY_W-1:0]     room;
	logic                 advance;
	logic [YEAR_W-1:0]    red_sub;
	logic [MONTH_W-1:0]   month_n;
	logic [DAY_W-1:0]     day_n;
	logic [YEAR_W-1:0]    year_n;
	logic [YEAR_W-1:0]    rem_n;
	logic [ADD_WIDTH-1:0] left_n;
	logic                 ovf_n;

	// month length in the working year
	assign len  = month_len(month_q, is_leap(rem_q[8:0]));
	assign room = len - day_q;

	assign advance     = left_q > ADD_WIDTH'(room);
	assign stat.finish = !advance;
	assign red_sub     = YEAR_W'(CYCLE_YEARS) << cmd.red_shift;

	// one month step
	always_comb begin
		month_n = month_q;
		day_n   = day_q;
		year_n  = year_q;
		rem_n   = rem_q;
		left_n  = left_q;
		ovf_n   = ovf_q;
		if (advance) begin
			left_n = left_q - ADD_WIDTH'(room) - ADD_WIDTH'(1);
			day_n  = DAY_W'(1);
			if (month_q == MONTH_DEC) begin
				month_n = MONTH_JAN;
				if (year_q == YEAR_MAX) begin
					year_n = '0;
					rem_n  = '0;
					ovf_n  = 1'b1;
				end else begin
					year_n = year_q + YEAR_W'(1);
					rem_n  = (rem_q[8:0] == CYCLE_LAST) ? '0 : rem_q + YEAR_W'(1);
				end
			end else begin
				month_n = month_q + MONTH_W'(1);
			end
		end else begin
			day_n  = day_q + DAY_W'(left_q);
			left_n = '0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (start_month == '0) begin
				month_q <= MONTH_JAN;
			end else if (start_month > MONTH_DEC) begin
				month_q <= MONTH_DEC;
			end else begin
				month_q <= start_month;
			end
			day_q  <= (start_day == '0) ? DAY_W'(1) : start_day;
			year_q <= start_year;
			rem_q  <= start_year;
			left_q <= day_count[ADD_WIDTH-1:0];
			ovf_q  <= 1'b0;
		end else if (cmd.reduce) begin
			// restoring reduction of the year modulo 400
			if (rem_q >= red_sub) rem_q <= rem_q - red_sub;
		end else if (cmd.clamp) begin
			if (day_q > len) day_q <= len;
		end else if (cmd.walk) begin
			month_q <= month_n;
			day_q   <= day_n;
			year_q  <= year_n;
			rem_q   <= rem_n;
			left_q  <= left_n;
			ovf_q   <= ovf_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			end_month     <= month_n;
			end_day       <= day_n;
			end_year      <= year_n;
			year_overflow <= ovf_n;
		end
	end

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> rem_q < YEAR_W'(CYCLE_YEARS))
		else $error("year remainder not reduced");

	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (day_q >= DAY_W'(1)) && (day_q <= len))
		else $error("working day outside month");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC))
		else $error("working month out of range");

endmodule

`default_nettype wire

FILE: rtl/core/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a start date and a day count;
//   an item is taken when in_valid is high and in_stall is low. in_stall is
//   high while an item is being worked on.
//   Output channel (out_valid / out_stall) gives the end date and the year
//   overflow flag; the result register holds its value while out_stall is
//   high, and a new item may be taken while a result waits there.
// Sequence: after the accepting edge, the year is reduced modulo 400,
//   one bit per cycle, then the day is clamped to the month length, then
//   the walk takes one month step per month crossed and a final step that
//   places the day and publishes the result. One item is in work at a
//   time, so a new item is taken only after its predecessor is published.
// If the result register is still full and stalled when the walk ends, the
//   walk holds until it frees.
// Reset (arst_n low) clears the sequencer and the result valid flag at once.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days import gda_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [MONTH_W-1:0] start_month,
	input  wire logic [DAY_W-1:0]   start_day,
	input  wire logic [YEAR_W-1:0]  start_year,
	input  wire logic [15:0]        day_count,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [MONTH_W-1:0]      end_month,
	output logic [DAY_W-1:0]        end_day,
	output logic [YEAR_W-1:0]       end_year,
	output logic                    year_overflow
);

	gda_cmd_t  cmd;
	gda_stat_t stat;

	// sequencer
	gda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// date datapath
	gda_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.start_month   (start_month),
		.start_day     (start_day),
		.start_year    (start_year),
		.day_count     (day_count),
		.end_month     (end_month),
		.end_day       (end_day),
		.end_year      (end_year),
		.year_overflow (year_overflow)
	);

endmodule

`default_nettype wire
